### rtl/itp_pkg.sv
// Shared codes, types and helpers for the infix to postfix converter.
// Used by itp_datapath, itp_controller, the top level and the checker.
package itp_pkg;

  // Input token kinds
  localparam logic [2:0] K_OPERAND  = 3'd0;
  localparam logic [2:0] K_OPERATOR = 3'd1;
  localparam logic [2:0] K_LPAREN   = 3'd2;
  localparam logic [2:0] K_RPAREN   = 3'd3;
  localparam logic [2:0] K_END      = 3'd4;

  // Result kinds
  localparam logic [1:0] OK_OPERAND  = 2'd0;
  localparam logic [1:0] OK_OPERATOR = 2'd1;
  localparam logic [1:0] OK_LPAREN   = 2'd2;
  localparam logic [1:0] OK_END      = 2'd3;

  // Stack entry: 0..3 operator code, 4 marks a '('
  localparam logic [2:0] MARK_LPAREN = 3'd4;

  // Stream widths
  localparam int unsigned InDataW  = 24;  // operand_ref, op_code, zero fill
  localparam int unsigned InUserW  = 3;   // kind
  localparam int unsigned OutDataW = 24;  // out_operand, out_op, overflow_seen, fill
  localparam int unsigned OutUserW = 2;   // out_kind

  // Source of a new result
  typedef enum logic [1:0] {
    SEL_OPERAND,
    SEL_TOP,
    SEL_END
  } sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;     // latch the accepted token
    logic rd;       // read the top of stack
    logic pop;      // drop the top of stack
    logic push;     // push operator or '(' mark
    logic emit;     // produce a result into the hold stage
    sel_e emit_sel;
    logic flush;    // send the held result out as the last one
    logic clr_ovf;  // clear sticky overflow
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] kind;
    logic       empty;
    logic       top_pops;   // top rank >= rank of current operator
    logic       top_is_lp;
    logic       hold_valid;
    logic       out_free;   // output register can take a transfer this cycle
  } sts_t;

  // Precedence of a stack entry; '(' ranks lowest
  function automatic logic [1:0] rank_f(logic [2:0] e);
    logic [1:0] r;
    if (e == MARK_LPAREN) begin
      r = 2'd0;
    end else if (e[1]) begin
      r = 2'd2;
    end else begin
      r = 2'd1;
    end
    return r;
  endfunction

endpackage

### rtl/itp_datapath.sv
// Datapath of the infix to postfix converter: token register, operator stack
// memory, counters, result hold stage and output register. Depends on itp_pkg.
module itp_datapath #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  itp_pkg::cmd_t                  cmd_i,
  output itp_pkg::sts_t                  sts_o,
  input  logic [15:0]                    in_operand_i,
  input  logic [1:0]                     in_op_i,
  input  logic [2:0]                     in_kind_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     out_kind_o,
  output logic [15:0]                    out_operand_o,
  output logic [1:0]                     out_op_o,
  output logic                           out_ovf_o,
  output logic                           out_last_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Token register
  logic [2:0]  kind_q;
  logic [15:0] operand_q;
  logic [1:0]  op_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= in_kind_i;
      operand_q <= in_operand_i;
      op_q      <= in_op_i;
    end
  end

  // Operator stack
  logic [2:0]    stack_mem [STACK_DEPTH];
  logic [2:0]    rd_q;
  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          full;
  logic [2:0]    push_entry;
  logic [CW-1:0] top_idx;

  assign full       = (count_q == CW'(STACK_DEPTH));
  assign push_entry = (kind_q == itp_pkg::K_LPAREN) ? itp_pkg::MARK_LPAREN : {1'b0, op_q};
  assign top_idx    = count_q - CW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      stack_mem[count_q[AW-1:0]] <= push_entry;
    end
    if (cmd_i.rd) begin
      rd_q <= stack_mem[top_idx[AW-1:0]];
    end
  end

  // Fill count and sticky overflow
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (cmd_i.push) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        count_d = count_q + CW'(1);
      end
    end else if (cmd_i.pop) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.clr_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  // New result fields
  logic [1:0]  new_kind;
  logic [15:0] new_operand;
  logic [1:0]  new_op;
  logic        new_ovf;

  always_comb begin
    new_kind    = itp_pkg::OK_END;
    new_operand = '0;
    new_op      = '0;
    new_ovf     = 1'b0;
    case (cmd_i.emit_sel)
      itp_pkg::SEL_OPERAND: begin
        new_kind    = itp_pkg::OK_OPERAND;
        new_operand = operand_q;
      end
      itp_pkg::SEL_TOP: begin
        if (rd_q == itp_pkg::MARK_LPAREN) begin
          new_kind = itp_pkg::OK_LPAREN;
        end else begin
          new_kind = itp_pkg::OK_OPERATOR;
          new_op   = rd_q[1:0];
        end
      end
      default: begin
        new_kind = itp_pkg::OK_END;
        new_ovf  = ovf_q;
      end
    endcase
  end

  // Hold stage: a result waits here until we know whether another follows
  logic        hold_valid_q;
  logic [1:0]  hold_kind_q;
  logic [15:0] hold_operand_q;
  logic [1:0]  hold_op_q;
  logic        hold_ovf_q;
  logic        move;

  assign move = (cmd_i.emit || cmd_i.flush) && hold_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      hold_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      hold_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      hold_kind_q    <= new_kind;
      hold_operand_q <= new_operand;
      hold_op_q      <= new_op;
      hold_ovf_q     <= new_ovf;
    end
  end

  // Output register
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [15:0] out_operand_q;
  logic [1:0]  out_op_q;
  logic        out_ovf_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (move) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_kind_q    <= hold_kind_q;
      out_operand_q <= hold_operand_q;
      out_op_q      <= hold_op_q;
      out_ovf_q     <= hold_ovf_q;
      out_last_q    <= cmd_i.flush;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_operand_o = out_operand_q;
  assign out_op_o      = out_op_q;
  assign out_ovf_o     = out_ovf_q;
  assign out_last_o    = out_last_q;

  // Status
  assign sts_o.kind       = kind_q;
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.top_pops   = (itp_pkg::rank_f(rd_q) >= itp_pkg::rank_f({1'b0, op_q}));
  assign sts_o.top_is_lp  = (rd_q == itp_pkg::MARK_LPAREN);
  assign sts_o.hold_valid = hold_valid_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

### rtl/itp_controller.sv
// Sequencer of the infix to postfix converter: walks one token through
// dispatch, stack reads and pops, and result flush. Depends on itp_pkg.
module itp_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  itp_pkg::sts_t sts_i,
  output itp_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE     = 2'd0;
  localparam logic [1:0] S_DISPATCH = 2'd1;
  localparam logic [1:0] S_TOP      = 2'd2;
  localparam logic [1:0] S_FINISH   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       can_emit;

  // Emitting moves a held result out, so the output must be free then
  assign can_emit   = !sts_i.hold_valid || sts_i.out_free;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.emit_sel = itp_pkg::SEL_TOP;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      // Decide on the token with the current stack count
      S_DISPATCH: begin
        case (sts_i.kind)
          itp_pkg::K_OPERAND: begin
            if (can_emit) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = itp_pkg::SEL_OPERAND;
              state_d        = S_FINISH;
            end
          end
          itp_pkg::K_LPAREN: begin
            cmd_o.push = 1'b1;
            state_d    = S_FINISH;
          end
          itp_pkg::K_OPERATOR: begin
            if (sts_i.empty) begin
              cmd_o.push = 1'b1;
              state_d    = S_FINISH;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_TOP;
            end
          end
          itp_pkg::K_RPAREN: begin
            if (sts_i.empty) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.rd = 1'b1;
              state_d  = S_TOP;
            end
          end
          itp_pkg::K_END: begin
            if (!sts_i.empty) begin
              cmd_o.rd = 1'b1;
              state_d  = S_TOP;
            end else if (can_emit) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_sel = itp_pkg::SEL_END;
              cmd_o.clr_ovf  = 1'b1;
              state_d        = S_FINISH;
            end
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      // Top of stack is in the read register
      S_TOP: begin
        case (sts_i.kind)
          itp_pkg::K_OPERATOR: begin
            if (!sts_i.top_pops) begin
              cmd_o.push = 1'b1;
              state_d    = S_FINISH;
            end else if (can_emit) begin
              cmd_o.emit = 1'b1;
              cmd_o.pop  = 1'b1;
              state_d    = S_DISPATCH;
            end
          end
          itp_pkg::K_RPAREN: begin
            if (sts_i.top_is_lp) begin
              cmd_o.pop = 1'b1;
              state_d   = S_FINISH;
            end else if (can_emit) begin
              cmd_o.emit = 1'b1;
              cmd_o.pop  = 1'b1;
              state_d    = S_DISPATCH;
            end
          end
          default: begin
            if (can_emit) begin
              cmd_o.emit = 1'b1;
              cmd_o.pop  = 1'b1;
              state_d    = S_DISPATCH;
            end
          end
        endcase
      end
      // Send the held result with last set
      S_FINISH: begin
        if (!sts_i.hold_valid) begin
          state_d = S_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/infix_to_postfix_converter.sv
// Top level of the shunting-yard infix to postfix converter.
// Instantiates itp_controller and itp_datapath; depends on itp_pkg.
//
// Tokens enter on the s_axis side one at a time and leave on the m_axis side
// in postfix order; tlast marks the final result of each input token, and an
// end token flushes the operator stack and closes with an end result whose
// overflow bit reports any push dropped on a full stack since the previous
// end. One token is worked at a time: s_axis_tready stays low from its
// transfer until the sequencer is back in idle. Every entry popped takes a
// registered read of the stack memory and then a step to decide and pop; an
// entry that is read and ends the loop (an operator of lower rank, or the
// matching '(' that is dropped) takes only the read and the decide step.
// A stall on the output side holds up the work of a token. Results pass
// through a one-deep hold stage and an output register.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] operand_ref, [17:16] op_code, [23:18] zero
  input  logic [itp_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] kind
  input  logic [itp_pkg::InUserW-1:0]   s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] out_operand, [17:16] out_op, [18] overflow_seen, [23:19] zero
  output logic [itp_pkg::OutDataW-1:0]  m_axis_tdata,
  // [1:0] out_kind
  output logic [itp_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast
);

  itp_pkg::cmd_t cmd;
  itp_pkg::sts_t sts;
  logic [15:0]   out_operand;
  logic [1:0]    out_op;
  logic          out_ovf;

  // Sequencer
  itp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Stack and result path
  itp_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_operand_i  (s_axis_tdata[15:0]),
    .in_op_i       (s_axis_tdata[17:16]),
    .in_kind_i     (s_axis_tuser[2:0]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_kind_o    (m_axis_tuser),
    .out_operand_o (out_operand),
    .out_op_o      (out_op),
    .out_ovf_o     (out_ovf),
    .out_last_o    (m_axis_tlast)
  );

  // Pack result fields
  assign m_axis_tdata = {5'd0, out_ovf, out_op, out_operand};

endmodule

### rtl/itp_checker.sv
// Port-level checks for infix_to_postfix_converter, attached with bind.
// Depends on itp_pkg.
module itp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [itp_pkg::InDataW-1:0]   s_axis_tdata,
  input logic [itp_pkg::InUserW-1:0]   s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [itp_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [itp_pkg::OutUserW-1:0]  m_axis_tuser,
  input logic                          m_axis_tlast
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Overflow is reported on end results only
  a_ovf_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != itp_pkg::OK_END) |-> !m_axis_tdata[18])
    else $error("overflow bit on a non-end result");

  // End and operand results always close their token
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == itp_pkg::OK_END)
      || (m_axis_tuser == itp_pkg::OK_OPERAND)) |-> m_axis_tlast)
    else $error("end or operand result without tlast");

  // A leftover '(' is always followed by more flush output
  a_lp_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == itp_pkg::OK_LPAREN) |-> !m_axis_tlast)
    else $error("leftover paren marked last");

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);

### bench/infix_to_postfix_converter_test.sv
// Self-checking bench for infix_to_postfix_converter: drives token streams and
// compares every output transfer against an in-bench shunting-yard model.
// Depends on itp_pkg and the converter RTL only.
module infix_to_postfix_converter_test;

  localparam int unsigned STACK_DEPTH     = 16;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int unsigned PHASE_TOKENS    = 45;

  // Codes taken from the package
  localparam logic [2:0] K_OPERAND   = itp_pkg::K_OPERAND;
  localparam logic [2:0] K_OPERATOR  = itp_pkg::K_OPERATOR;
  localparam logic [2:0] K_LPAREN    = itp_pkg::K_LPAREN;
  localparam logic [2:0] K_RPAREN    = itp_pkg::K_RPAREN;
  localparam logic [2:0] K_END       = itp_pkg::K_END;
  localparam logic [1:0] OK_OPERAND  = itp_pkg::OK_OPERAND;
  localparam logic [1:0] OK_OPERATOR = itp_pkg::OK_OPERATOR;
  localparam logic [1:0] OK_LPAREN   = itp_pkg::OK_LPAREN;
  localparam logic [1:0] OK_END      = itp_pkg::OK_END;
  localparam logic [2:0] MARK_LPAREN = itp_pkg::MARK_LPAREN;

  // Operator codes; unused op fields read as zero
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_SUB  = 2'd1;
  localparam logic [1:0] OP_MUL  = 2'd2;
  localparam logic [1:0] OP_DIV  = 2'd3;
  localparam logic [1:0] OP_NONE = 2'd0;

  // Token kinds the block ignores
  localparam logic [2:0] K_RSVD_5 = 3'd5;
  localparam logic [2:0] K_RSVD_6 = 3'd6;
  localparam logic [2:0] K_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] operand;
    logic [1:0]  op;
  } token_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] operand;
    logic [1:0]  op;
    logic        ovf;
    logic        last;
  } postfix_t;

  typedef struct packed {
    token_t   tok;
    logic     typed;  // expected result given in the row
    postfix_t want;
  } dir_row_t;

  localparam postfix_t NO_RESULT = '0;

  // Directed tokens; typed rows give exactly one result
  localparam dir_row_t DIRECTED [25] = '{
    '{'{K_END,      16'h0000, OP_NONE}, 1'b1, '{OK_END,     16'h0000, OP_NONE, 1'b0, 1'b1}},
    '{'{K_OPERAND,  16'h0000, OP_DIV},  1'b1, '{OK_OPERAND, 16'h0000, OP_NONE, 1'b0, 1'b1}},
    '{'{K_OPERAND,  16'hFFFF, OP_NONE}, 1'b1, '{OK_OPERAND, 16'hFFFF, OP_NONE, 1'b0, 1'b1}},
    '{'{K_OPERATOR, 16'hFFFF, OP_ADD},  1'b0, NO_RESULT},
    '{'{K_OPERAND,  16'h1234, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_OPERATOR, 16'h0000, OP_MUL},  1'b0, NO_RESULT},
    '{'{K_OPERAND,  16'h8001, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_OPERATOR, 16'h0000, OP_SUB},  1'b0, NO_RESULT},  // pops '*' then '+'
    '{'{K_LPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_OPERAND,  16'h00FF, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_OPERATOR, 16'h0000, OP_DIV},  1'b0, NO_RESULT},  // never pops a '('
    '{'{K_OPERAND,  16'hFF00, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_RPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_END,      16'h5A5A, OP_DIV},  1'b0, NO_RESULT},
    '{'{K_RPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},  // unmatched on empty stack
    '{'{K_OPERATOR, 16'h0000, OP_ADD},  1'b0, NO_RESULT},
    '{'{K_OPERATOR, 16'h0000, OP_MUL},  1'b0, NO_RESULT},
    '{'{K_RPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},  // unmatched, flushes operators
    '{'{K_RSVD_5,   16'hFFFF, OP_DIV},  1'b0, NO_RESULT},
    '{'{K_RSVD_6,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_RSVD_7,   16'hA5A5, OP_SUB},  1'b0, NO_RESULT},
    '{'{K_LPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_OPERATOR, 16'h0000, OP_SUB},  1'b0, NO_RESULT},
    '{'{K_LPAREN,   16'h0000, OP_NONE}, 1'b0, NO_RESULT},
    '{'{K_END,      16'h0000, OP_NONE}, 1'b0, NO_RESULT}   // leftover '(' marks flushed
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] operand_ref, [17:16] op_code, [23:18] zero
  logic [23:0] s_axis_tdata = '0;
  // [2:0] kind
  logic [2:0]  s_axis_tuser = K_OPERAND;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] out_operand, [17:16] out_op, [18] overflow_seen, [23:19] zero
  logic [23:0] m_axis_tdata;
  // [1:0] out_kind
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Model state and bench bookkeeping
  logic [2:0]  op_stack_q [$];
  logic        ovf_sticky = 1'b0;
  postfix_t    postfix_q [$];
  token_t      token_q [$];
  int unsigned tokens_queued = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off_req = 1'b0;
  logic        hold_off_seen = 1'b0;
  int unsigned hold_left = 0;

  infix_to_postfix_converter #(
    .STACK_DEPTH(STACK_DEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Precedence: '(' lowest, then + -, then * /
  function automatic int unsigned prec(logic [2:0] entry);
    if (entry == MARK_LPAREN) return 0;
    return (entry[1]) ? 2 : 1;
  endfunction

  function automatic void push_entry(logic [2:0] entry);
    if (op_stack_q.size() < STACK_DEPTH) begin
      op_stack_q.insert(op_stack_q.size(), entry);
    end else begin
      ovf_sticky = 1'b1;
    end
  endfunction

  // Remove and return the top of the model stack
  function automatic logic [2:0] stack_take();
    logic [2:0] e;
    e = op_stack_q[$];
    op_stack_q.delete(op_stack_q.size() - 1);
    return e;
  endfunction

  // Shunting-yard step: updates the model stack and, if record is set,
  // queues the postfix results of one token
  function automatic int unsigned to_postfix(token_t t, bit record);
    postfix_t   res [$];
    logic [2:0] top;
    case (t.kind)
      K_OPERAND: begin
        res.insert(res.size(), postfix_t'{OK_OPERAND, t.operand, OP_NONE, 1'b0, 1'b0});
      end
      K_OPERATOR: begin
        while (op_stack_q.size() != 0 && prec(op_stack_q[$]) >= prec({1'b0, t.op})) begin
          top = stack_take();
          res.insert(res.size(), postfix_t'{OK_OPERATOR, 16'h0000, top[1:0], 1'b0, 1'b0});
        end
        push_entry({1'b0, t.op});
      end
      K_LPAREN: begin
        push_entry(MARK_LPAREN);
      end
      K_RPAREN: begin
        while (op_stack_q.size() != 0) begin
          top = stack_take();
          if (top == MARK_LPAREN) break;
          res.insert(res.size(), postfix_t'{OK_OPERATOR, 16'h0000, top[1:0], 1'b0, 1'b0});
        end
      end
      K_END: begin
        while (op_stack_q.size() != 0) begin
          top = stack_take();
          if (top == MARK_LPAREN) begin
            res.insert(res.size(), postfix_t'{OK_LPAREN, 16'h0000, OP_NONE, 1'b0, 1'b0});
          end else begin
            res.insert(res.size(), postfix_t'{OK_OPERATOR, 16'h0000, top[1:0], 1'b0, 1'b0});
          end
        end
        res.insert(res.size(), postfix_t'{OK_END, 16'h0000, OP_NONE, ovf_sticky, 1'b0});
        ovf_sticky = 1'b0;
      end
      default: begin
      end
    endcase
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    if (record) begin
      foreach (res[i]) postfix_q.insert(postfix_q.size(), res[i]);
    end
    return res.size();
  endfunction

  // Token with random don't-care fields; operands lean toward the extremes
  function automatic void add_token(logic [2:0] kind);
    token_t t;
    t.kind = kind;
    t.op = 2'($urandom_range(OP_DIV, OP_ADD));
    case ($urandom_range(7))
      0:       t.operand = 16'h0000;
      1:       t.operand = 16'hFFFF;
      default: t.operand = 16'($urandom);
    endcase
    token_q.insert(token_q.size(), t);
    if (kind <= K_END) tokens_queued++;
  endfunction

  // Infix expression with random nesting; a broken one leaves parens
  // unbalanced or drops its end mark
  function automatic void add_expression(bit broken);
    int unsigned open_n;
    int unsigned terms;
    int unsigned max_nest;
    open_n = 0;
    terms = $urandom_range(8, 1);
    max_nest = $urandom_range(6, 0);
    for (int unsigned i = 0; i < terms; i++) begin
      if (i != 0) add_token(K_OPERATOR);
      while (open_n < max_nest && $urandom_range(2) == 0) begin
        add_token(K_LPAREN);
        open_n++;
      end
      add_token(K_OPERAND);
      while (open_n > 0 && $urandom_range(2) == 0) begin
        add_token(K_RPAREN);
        open_n--;
      end
    end
    if (!broken) begin
      repeat (open_n) add_token(K_RPAREN);
      add_token(K_END);
    end else begin
      case ($urandom_range(2))
        0: add_token(K_END);
        1: begin
          repeat ($urandom_range(3, 1)) add_token(K_RPAREN);
          add_token(K_END);
        end
        default: add_token(K_OPERATOR);  // runs into the next expression
      endcase
    end
  endfunction

  // Nesting deeper than the stack, so pushes are dropped before the end mark
  function automatic void add_deep_nest();
    repeat (STACK_DEPTH + $urandom_range(4, 1)) begin
      add_token(K_LPAREN);
      if ($urandom_range(1) == 0) begin
        add_token(K_OPERAND);
        add_token(K_OPERATOR);
      end
    end
    add_token(K_OPERAND);
    repeat ($urandom_range(3)) add_token(K_RPAREN);
    add_token(K_END);
  endfunction

  // Offer one token after a random idle gap, wait for its transfer, predict
  task automatic send_token(token_t t, bit typed, postfix_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= t.kind;
    s_axis_tdata  <= {6'b0, t.op, t.operand};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    void'(to_postfix(t, !typed));
    if (typed) postfix_q.insert(postfix_q.size(), want);
  endtask

  task automatic send_queued();
    while (token_q.size() != 0) send_token(token_q.pop_front(), 1'b0, NO_RESULT);
  endtask

  // Stop offering and wait for every expected result
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (postfix_q.size() != 0);
  endtask

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Output side: check each transfer, then pick next tready
  always @(posedge clk_i) begin
    postfix_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (postfix_q.size() == 0) begin
        $error("unexpected result transfer: kind %0h data %0h last %0b",
               m_axis_tuser, m_axis_tdata, m_axis_tlast);
        error_count++;
      end else begin
        want = postfix_q.pop_front();
        check_field("out_kind", 16'(want.kind), 16'(m_axis_tuser));
        check_field("out_operand", want.operand, m_axis_tdata[15:0]);
        check_field("out_op", 16'(want.op), 16'(m_axis_tdata[17:16]));
        check_field("overflow_seen", 16'(want.ovf), 16'(m_axis_tdata[18]));
        check_field("last", 16'(want.last), 16'(m_axis_tlast));
      end
    end
    // long hold-off on request, otherwise random stalls
    if (hold_off_req != hold_off_seen) begin
      hold_off_seen = hold_off_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tokens, then one overflowing expression
    foreach (DIRECTED[i]) send_token(DIRECTED[i].tok, DIRECTED[i].typed, DIRECTED[i].want);
    add_deep_nest();
    send_queued();
    drain();

    // Random phases: none, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct <= 0;
          hold_off_req <= ~hold_off_req;  // block fills while sender keeps offering
        end
        1: begin
          send_idle_pct = 74;
          recv_stall_pct <= 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct <= 74;
        end
        default: begin
          send_idle_pct = 36;
          recv_stall_pct <= 36;
        end
      endcase
      phase_start = tokens_queued;
      while (tokens_queued - phase_start < PHASE_TOKENS) begin
        case ($urandom_range(99)) inside
          [0:74]:  add_expression(1'b0);
          [75:84]: add_expression(1'b1);
          [85:92]: repeat ($urandom_range(6, 1)) add_token(3'($urandom_range(K_RSVD_7, K_OPERAND)));
          default: add_deep_nest();
        endcase
      end
      send_queued();
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/itp_pkg.sv
rtl/itp_datapath.sv
rtl/itp_controller.sv
rtl/infix_to_postfix_converter.sv
rtl/itp_checker.sv
bench/infix_to_postfix_converter_test.sv
